// File: hdl/stl_pkg.sv
package stl_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;

    localparam logic [5:0] KIND_EOF     = 6'd0;
    localparam logic [5:0] KIND_ILLEGAL = 6'd1;
    localparam logic [5:0] KIND_INT     = 6'd2;
    localparam logic [5:0] KIND_FLOAT   = 6'd3;
    localparam logic [5:0] KIND_STRING  = 6'd4;
    localparam logic [5:0] KIND_IDENT   = 6'd5;
    localparam logic [5:0] KIND_SYM0    = 6'd6;
    localparam logic [5:0] KIND_ASSIGN  = 6'd15;
    localparam logic [5:0] KIND_BOOL    = 6'd34;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL = 2'd1;
    localparam logic [1:0] ERR_POINTS  = 2'd2;
    localparam logic [1:0] ERR_UNCLOSED = 2'd3;

    localparam logic [7:0] CH_SKIP_MAX = 8'd37;
    localparam int         WORD_MAX    = 6;

    // one token as it travels to the output
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [1:0]  err;
        logic        last;
    } t_token;

    // up to three tokens caused by one byte
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
        t_token     tok2;
    } t_group;

    function automatic logic [5:0] sym_kind(input logic [7:0] c);
        case (c)
            8'h3B:   return 6'd6;
            8'h28:   return 6'd7;
            8'h29:   return 6'd8;
            8'h7D:   return 6'd9;
            8'h7B:   return 6'd10;
            8'h2B:   return 6'd11;
            8'h2D:   return 6'd12;
            8'h2A:   return 6'd13;
            8'h2F:   return 6'd14;
            8'h3D:   return 6'd15;
            8'h2E:   return 6'd16;
            8'h2C:   return 6'd17;
            8'h3E:   return 6'd18;
            8'h3C:   return 6'd19;
            8'h25:   return 6'd20;
            8'h5B:   return 6'd21;
            8'h5D:   return 6'd22;
            default: return 6'd0;
        endcase
    endfunction

    // compound form of an operator kind, zero when it does not merge
    function automatic logic [5:0] merge_kind(input logic [5:0] k);
        case (k)
            6'd11:   return 6'd35;
            6'd12:   return 6'd36;
            6'd13:   return 6'd37;
            6'd14:   return 6'd38;
            6'd20:   return 6'd39;
            6'd15:   return 6'd40;
            6'd18:   return 6'd41;
            6'd19:   return 6'd42;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [2:0] n);
        case ({n, w})
            {3'd6, 48'h72_65_74_75_72_6E}: return 6'd23;
            {3'd4, 48'h00_00_66_75_6E_63}: return 6'd24;
            {3'd2, 48'h00_00_00_00_69_66}: return 6'd25;
            {3'd3, 48'h00_00_00_61_6E_64}: return 6'd26;
            {3'd2, 48'h00_00_00_00_6F_72}: return 6'd27;
            {3'd3, 48'h00_00_00_6E_6F_74}: return 6'd28;
            {3'd3, 48'h00_00_00_66_6F_72}: return 6'd29;
            {3'd5, 48'h00_77_68_69_6C_65}: return 6'd30;
            {3'd5, 48'h00_63_6C_61_73_73}: return 6'd31;
            {3'd4, 48'h00_00_65_6C_73_65}: return 6'd32;
            {3'd3, 48'h00_00_00_74_72_79}: return 6'd33;
            {3'd4, 48'h00_00_74_72_75_65}: return KIND_BOOL;
            {3'd5, 48'h00_66_61_6C_73_65}: return KIND_BOOL;
            default:                       return KIND_IDENT;
        endcase
    endfunction

endpackage

// File: hdl/script_token_lexer.sv
// Streaming lexer: one source byte per slave transfer, tokens on the master side.
// Slave channel: s_axis_tdata carries the byte; 0 ends the text, emits eof and
// returns every counter to its reset state for the next text.
// Master channel: one transfer per token; tdata holds kind, line, column and
// error code; tlast marks the last token caused by one input byte.
// Throughput: one byte per cycle while the queue is not full. The front
// stage classifies a byte in the cycle it is accepted and pushes its 1 to 3
// tokens, if any, as one group into a four-group queue; the back stage sends
// one token per cycle from it while the receiver is ready.
// An operator is held until the next token, so it may surface later, merged
// with a following '=' into a compound.
// When the receiver stalls, the queue fills and s_axis_tready drops only when
// all four groups are taken; bytes yielding no token still need a free slot.
// Reset (i_rst_n low, synchronous) empties the queue and clears the lexer.
module script_token_lexer #(
    parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = stl_pkg::COLUMN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [5:0] kind, [21:6] line, [37:22] column,
                                        // [39:38] error_code
    output logic        m_axis_tlast
);
    import stl_pkg::*;

    logic   push, full;
    t_group grp;
    t_token tok;

    stl_front #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .i_byte(s_axis_tdata), .o_ready(s_axis_tready),
        .o_push(push), .o_group(grp), .i_full(full)
    );

    stl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_group(grp), .o_full(full),
        .o_valid(m_axis_tvalid), .o_token(tok), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {tok.err, tok.column, tok.line, tok.kind};
    assign m_axis_tlast = tok.last;
endmodule

// File: hdl/stl_front.sv
module stl_front #(
    parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = stl_pkg::COLUMN_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_ready,
    output logic              o_push,
    output stl_pkg::t_group   o_group,
    input  logic              i_full
);
    import stl_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE   = 4'b0001,
        M_NUMBER = 4'b0010,
        M_STRING = 4'b0100,
        M_IDENT  = 4'b1000
    } t_mode;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    t_mode r_mode, n_mode;
    logic r_point, n_point, r_esc, n_esc, r_single, n_single;
    logic [47:0] r_word, n_word;
    logic [2:0]  r_wlen, n_wlen;
    logic [LINE_BITS-1:0]   r_line, n_line, r_sline, n_sline, r_hline, n_hline;
    logic [COLUMN_BITS-1:0] r_col, n_col, r_scol, n_scol, r_hcol, n_hcol;
    logic [5:0] r_hkind, n_hkind;
    logic       r_hvalid, n_hvalid;

    logic       fire;
    logic [1:0] cnt;
    t_token     toks [3];
    logic       to_idle, ended;
    logic       is_dig, is_alp;
    logic [5:0] sk;

    assign o_ready = !i_full;
    assign fire    = i_valid && !i_full;
    assign is_dig  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_alp  = ((i_byte >= 8'h61) && (i_byte <= 8'h7A))
                  || ((i_byte >= 8'h41) && (i_byte <= 8'h5A));
    assign sk      = sym_kind(i_byte);

    // classify the byte and build its tokens, with the held operator merge
    always_comb begin
        logic [5:0]  pk;
        logic [15:0] pl, pc;
        logic [1:0]  pe;
        logic        pv;
        logic        p2v;
        logic [5:0]  p2k;
        logic [15:0] p2l, p2c;
        logic [1:0]  p2e;
        n_mode = r_mode; n_point = r_point; n_esc = r_esc; n_single = r_single;
        n_word = r_word; n_wlen = r_wlen; n_line = r_line; n_col = r_col;
        n_sline = r_sline; n_scol = r_scol; n_hline = r_hline; n_hcol = r_hcol;
        n_hkind = r_hkind; n_hvalid = r_hvalid;
        to_idle = (r_mode == M_IDLE);
        ended = 1'b0;
        pv = 1'b0; pk = '0; pl = '0; pc = '0; pe = ERR_NONE;
        p2v = 1'b0; p2k = '0; p2l = '0; p2c = '0; p2e = ERR_NONE;
        cnt = '0;
        for (int i = 0; i < 3; i++) toks[i] = '0;

        // first push: closing the token in progress
        case (r_mode)
            M_NUMBER: begin
                if (is_dig) begin
                end else if (i_byte == 8'h2E) begin
                    if (r_point) begin
                        pv = 1'b1; pk = KIND_ILLEGAL; pe = ERR_POINTS;
                        pl = 16'(r_sline); pc = 16'(r_scol);
                        n_mode = M_IDLE;
                    end else n_point = 1'b1;
                end else begin
                    pv = 1'b1; pk = r_point ? KIND_FLOAT : KIND_INT;
                    pl = 16'(r_sline); pc = 16'(r_scol);
                    n_mode = M_IDLE; to_idle = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_dig || is_alp || i_byte == 8'h5F) begin
                    if (r_wlen < 3'(WORD_MAX)) n_word = {r_word[39:0], i_byte};
                    if (r_wlen < 3'd7) n_wlen = r_wlen + 3'd1;
                end else begin
                    pv = 1'b1; pk = word_kind(r_word, r_wlen);
                    pl = 16'(r_sline); pc = 16'(r_scol);
                    n_mode = M_IDLE; to_idle = 1'b1;
                end
            end
            M_STRING: begin
                if (i_byte == 8'h00) begin
                    pv = 1'b1; pk = KIND_ILLEGAL; pe = ERR_UNCLOSED;
                    pl = 16'(r_sline); pc = 16'(r_scol);
                    n_mode = M_IDLE; to_idle = 1'b1;
                end else if (r_esc) n_esc = 1'b0;
                else if (i_byte == 8'h5C) n_esc = 1'b1;
                else if (i_byte == (r_single ? 8'h27 : 8'h22)) begin
                    pv = 1'b1; pk = KIND_STRING;
                    pl = 16'(r_sline); pc = 16'(r_scol);
                    n_mode = M_IDLE;
                end
            end
            default: ;
        endcase

        // second push: the byte seen from idle
        if (to_idle) begin
            if (i_byte == 8'h0A) begin
            end else if (i_byte == 8'h00) begin
                p2v = 1'b1; p2k = KIND_EOF; ended = 1'b1;
            end else if (sk != 6'd0) begin
                p2v = 1'b1; p2k = sk; p2l = 16'(r_line); p2c = 16'(r_col);
            end else if (is_dig) begin
                n_mode = M_NUMBER; n_point = 1'b0;
                n_sline = r_line; n_scol = r_col;
            end else if (i_byte == 8'h22 || i_byte == 8'h27) begin
                n_mode = M_STRING; n_single = (i_byte == 8'h27); n_esc = 1'b0;
                n_sline = r_line;
                n_scol = (r_col == COL_MAX) ? COL_MAX : r_col + 1'b1;
            end else if (is_alp) begin
                n_mode = M_IDENT; n_word = {40'd0, i_byte}; n_wlen = 3'd1;
                n_sline = r_line; n_scol = r_col;
            end else if (i_byte <= CH_SKIP_MAX || i_byte[7]) begin
            end else begin
                p2v = 1'b1; p2k = KIND_ILLEGAL; p2e = ERR_ILLEGAL;
                p2l = 16'(r_line); p2c = 16'(r_col);
            end
        end

        // resolve the pushes through the one-token hold
        begin
            logic       hv;
            logic [5:0] hk;
            logic [15:0] hl, hc;
            hv = r_hvalid; hk = r_hkind; hl = 16'(r_hline); hc = 16'(r_hcol);
            for (int p = 0; p < 2; p++) begin
                logic       v;
                logic [5:0] k;
                logic [15:0] l, c;
                logic [1:0] e;
                logic       done;
                v = (p == 0) ? pv : p2v;
                k = (p == 0) ? pk : p2k;
                l = (p == 0) ? pl : p2l;
                c = (p == 0) ? pc : p2c;
                e = (p == 0) ? pe : p2e;
                done = 1'b0;
                if (v) begin
                    if (hv) begin
                        hv = 1'b0;
                        toks[cnt] = '{kind: (k == KIND_ASSIGN && merge_kind(hk) != 6'd0)
                                            ? merge_kind(hk) : hk,
                                      line: hl, column: hc, err: ERR_NONE, last: 1'b0};
                        cnt = cnt + 2'd1;
                        done = (k == KIND_ASSIGN);
                    end
                    if (!done) begin
                        if (e == ERR_NONE && merge_kind(k) != 6'd0) begin
                            hv = 1'b1; hk = k; hl = l; hc = c;
                        end else begin
                            toks[cnt] = '{kind: k, line: l, column: c, err: e, last: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end
                end
            end
            n_hvalid = hv; n_hkind = hk;
            n_hline = LINE_BITS'(hl); n_hcol = COLUMN_BITS'(hc);
        end
        if (cnt != 2'd0) toks[cnt - 2'd1].last = 1'b1;

        // advance the position, or start over after end of text
        if (ended) begin
            n_mode = M_IDLE; n_point = 1'b0; n_esc = 1'b0; n_single = 1'b0;
            n_word = '0; n_wlen = '0; n_line = '0; n_col = '0;
            n_sline = '0; n_scol = '0; n_hkind = '0; n_hvalid = 1'b0;
            n_hline = '0; n_hcol = '0;
        end else if (i_byte == 8'h0A) begin
            n_line = (r_line == LINE_MAX) ? LINE_MAX : r_line + 1'b1;
            n_col = '0;
        end else begin
            n_col = (r_col == COL_MAX) ? COL_MAX : r_col + 1'b1;
        end
    end

    assign o_push  = fire && (cnt != 2'd0);
    assign o_group = '{count: cnt, tok0: toks[0], tok1: toks[1], tok2: toks[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_point <= 1'b0; r_esc <= 1'b0; r_single <= 1'b0;
            r_word <= '0; r_wlen <= '0; r_line <= '0; r_col <= '0;
            r_sline <= '0; r_scol <= '0; r_hkind <= '0; r_hvalid <= 1'b0;
            r_hline <= '0; r_hcol <= '0;
        end else if (fire) begin
            r_mode <= n_mode; r_point <= n_point; r_esc <= n_esc; r_single <= n_single;
            r_word <= n_word; r_wlen <= n_wlen; r_line <= n_line; r_col <= n_col;
            r_sline <= n_sline; r_scol <= n_scol; r_hkind <= n_hkind;
            r_hvalid <= n_hvalid; r_hline <= n_hline; r_hcol <= n_hcol;
        end
    end

    a_word_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_IDENT) |-> (r_wlen != 3'd0))
        else $error("identifier mode with empty word");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("push into full queue");
    a_eof_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ended) |=> (r_mode == M_IDLE && !r_hvalid && r_col == '0))
        else $error("state not cleared after end of text");
endmodule

// File: hdl/stl_back.sv
module stl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  stl_pkg::t_group   i_group,
    output logic              o_full,
    output logic              o_valid,
    output stl_pkg::t_token   o_token,
    input  logic              i_ready
);
    import stl_pkg::*;

    localparam int DEPTH = 4;

    t_group    r_q [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [1:0] r_sub;
    logic       pop, take;
    t_group    head;

    assign head    = r_q[r_rp];
    assign o_valid = (r_cnt != 3'd0);
    assign o_token = (r_sub == 2'd0) ? head.tok0 : (r_sub == 2'd1) ? head.tok1 : head.tok2;
    assign take    = o_valid && i_ready;
    assign pop     = take && (r_sub + 2'd1 == head.count);
    assign o_full  = (r_cnt == 3'(DEPTH));

    // store groups, then unroll each into single token transfers
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_sub <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (pop) begin
                r_rp <= r_rp + 2'd1; r_sub <= '0;
            end else if (take) r_sub <= r_sub + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(DEPTH))
        else $error("queue count overflow");
    a_last_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (o_token.last == pop))
        else $error("last flag disagrees with group end");
    a_group_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (head.count != 2'd0))
        else $error("empty group stored");
endmodule
